[hw/rtl/bpr_pkg.sv]
// Shared types, constants and codes for the bilinear resampler.
package bpr_pkg;

  localparam int MAX_SRC_DIM_DEF = 256;
  localparam int MAX_OUT_DIM_DEF = 256;

  localparam int SAMPLE_W   = 16;
  localparam int DIM_W      = 9;
  localparam int Q_W        = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WGT_W      = 17;
  localparam int H_W        = 32;
  localparam int ACC_W      = 48;
  localparam int VAL_W      = 40;
  localparam int SUM_W      = 56;
  localparam int DIV_STEPS  = 24;
  localparam int DCNT_W     = 5;

  localparam logic [DIM_W-1:0] SRC_ROWS_RST = 9'd64;
  localparam logic [DIM_W-1:0] SRC_COLS_RST = 9'd64;
  localparam logic [DIM_W-1:0] OUT_ROWS_RST = 9'd64;
  localparam logic [DIM_W-1:0] OUT_COLS_RST = 9'd64;
  localparam logic [Q_W-1:0]   STEP_RST     = 24'h010000;
  localparam logic [Q_W-1:0]   OFFSET_RST   = 24'h000000;
  localparam logic [WGT_W-1:0] FRAC_ONE     = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_HALF   = 48'd128;
  localparam logic [Q_W-1:0]   Q24_MAX      = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ROWS = 3'd0,
    CFG_SRC_COLS = 3'd1,
    CFG_OUT_ROWS = 3'd2,
    CFG_OUT_COLS = 3'd3,
    CFG_STEP     = 3'd4,
    CFG_COL_OFF  = 3'd5,
    CFG_ROW_OFF  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OPERATION_LOAD = 1'b0,
    OPERATION_READ = 1'b1
  } operation_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_G_INIT, ST_G_IDX, ST_G_BASE, ST_G_RD00, ST_G_RD01, ST_G_RD10,
    ST_G_RD11, ST_G_MUL, ST_G_ACC, ST_G_WR, ST_R_ADDR, ST_R_DATA, ST_R_DIV,
    ST_R_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_G_INIT, DP_G_IDX, DP_G_BASE, DP_G_RD00, DP_G_RD01,
    DP_G_RD10, DP_G_RD11, DP_G_MUL, DP_G_ACC, DP_G_WR, DP_R_ADDR, DP_R_DATA,
    DP_R_DIV, DP_R_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } bpr_cmd_t;

  typedef struct packed {
    logic computed;
    logic grid_last;
    logic skip_div;
    logic div_done;
    logic out_free;
  } bpr_sts_t;

endpackage

[hw/rtl/bpr_in_if.sv]
// Input channel: operation code and source sample with valid/ready.
interface bpr_in_if import bpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink (input valid, input operation, input sample, output ready);
endinterface

[hw/rtl/bpr_out_if.sv]
// Output channel: normalised pixel and its position with valid/ready.
interface bpr_out_if import bpr_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] pixel_value;
  logic [7:0]     pixel_row;
  logic [7:0]     pixel_col;
  logic           is_last;
  logic           zero_total;

  modport source (output valid, output pixel_value, output pixel_row, output pixel_col,
                  output is_last, output zero_total, input ready);
  modport sink (input valid, input pixel_value, input pixel_row, input pixel_col,
                input is_last, input zero_total, output ready);
endinterface

[hw/rtl/bpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/bpr_ctrl.sv]
// Sequencer for load, grid pass, division and result hand-off.
module bpr_ctrl import bpr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_op_i,
  output logic     in_ready_o,
  input  bpr_sts_t sts_i,
  output bpr_cmd_t cmd_o
);
  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OPERATION_LOAD) begin
            cmd_o.op = DP_LOAD;
          end else begin
            state_d = sts_i.computed ? ST_R_ADDR : ST_G_INIT;
          end
        end
      end
      ST_G_INIT: begin cmd_o.op = DP_G_INIT; state_d = ST_G_IDX; end
      ST_G_IDX:  begin cmd_o.op = DP_G_IDX;  state_d = ST_G_BASE; end
      ST_G_BASE: begin cmd_o.op = DP_G_BASE; state_d = ST_G_RD00; end
      ST_G_RD00: begin cmd_o.op = DP_G_RD00; state_d = ST_G_RD01; end
      ST_G_RD01: begin cmd_o.op = DP_G_RD01; state_d = ST_G_RD10; end
      ST_G_RD10: begin cmd_o.op = DP_G_RD10; state_d = ST_G_RD11; end
      ST_G_RD11: begin cmd_o.op = DP_G_RD11; state_d = ST_G_MUL; end
      ST_G_MUL:  begin cmd_o.op = DP_G_MUL;  state_d = ST_G_ACC; end
      ST_G_ACC:  begin cmd_o.op = DP_G_ACC;  state_d = ST_G_WR; end
      ST_G_WR: begin
        cmd_o.op = DP_G_WR;
        state_d  = sts_i.grid_last ? ST_R_ADDR : ST_G_IDX;
      end
      ST_R_ADDR: begin cmd_o.op = DP_R_ADDR; state_d = ST_R_DATA; end
      ST_R_DATA: begin
        cmd_o.op = DP_R_DATA;
        state_d  = sts_i.skip_div ? ST_R_OUT : ST_R_DIV;
      end
      ST_R_DIV: begin
        cmd_o.op = DP_R_DIV;
        if (sts_i.div_done) begin
          state_d = ST_R_OUT;
        end
      end
      ST_R_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_R_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_read_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_op_i == OPERATION_READ |=> state_q != ST_IDLE)
    else $error("read beat did not start work");
  a_grid_only_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_G_INIT |-> !sts_i.computed)
    else $error("grid pass started on a computed grid");
  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_R_DIV && !sts_i.div_done |=> state_q == ST_R_DIV)
    else $error("division left early");
`endif
endmodule

[hw/rtl/bpr_dp.sv]
// Datapath: configuration, source and grid stores, interpolation and divider.
module bpr_dp import bpr_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpr_cmd_t              cmd_i,
  output bpr_sts_t              sts_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [Q_W-1:0]        pixel_value_o,
  output logic [7:0]            pixel_row_o,
  output logic [7:0]            pixel_col_o,
  output logic                  is_last_o,
  output logic                  zero_total_o
);
  localparam int SDW = $clog2(MAX_SRC_DIM + 1);
  localparam int SIW = $clog2(MAX_SRC_DIM);
  localparam int SAW = $clog2(MAX_SRC_DIM * MAX_SRC_DIM);
  localparam int SNW = SAW + 1;
  localparam int ODW = $clog2(MAX_OUT_DIM + 1);
  localparam int OIW = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM) : 1;
  localparam int OAW = (MAX_OUT_DIM > 1) ? $clog2(MAX_OUT_DIM * MAX_OUT_DIM) : 1;
  localparam int PW  = Q_W + OIW;
  localparam int IW  = PW - 16;
  localparam int IW1 = IW + 1;
  localparam int RW  = SUM_W + 1;

  // configuration
  logic [DIM_W-1:0] src_rows_q, src_cols_q, out_rows_q, out_cols_q;
  logic [Q_W-1:0]   step_q, col_off_q, row_off_q;
  logic             cfg_hit;

  // control state
  logic           computed_q;
  logic [SNW-1:0] load_idx_q;
  logic [OAW-1:0] rd_idx_q;
  logic [OIW-1:0] rd_row_q, rd_col_q;
  logic           out_valid_q;

  // grid pass
  logic [OAW-1:0]   g_idx_q;
  logic [OIW-1:0]   g_row_q, g_col_q;
  logic [PW-1:0]    pos_y_q, pos_x_q;
  logic [SIW-1:0]   y0_q, y1_q, x0_q, x1_q;
  logic [WGT_W-1:0] gx_q, gy_q, fx_q, fy_q;
  logic [SAW-1:0]   rb0_q, rb1_q;
  logic [H_W-1:0]   h_q;
  logic [ACC_W-1:0] acc_q;
  logic [SUM_W-1:0] sum_q;

  // read and divide
  logic [RW-1:0]     rem_q;
  logic [Q_W-1:0]    quo_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              zero_q, sat_q;

  // result register
  logic [Q_W-1:0] out_val_q;
  logic [OIW-1:0] out_row_q, out_col_q;
  logic           out_last_q, out_zero_q;

  // clamped sizes
  logic [SDW-1:0] sr, sc;
  logic [ODW-1:0] orr, occ;
  logic [SIW-1:0] sr_last, sc_last;
  logic [OIW-1:0] orr_last, occ_last;
  logic [SNW-1:0] npix;
  logic           load_ok;

  always_comb begin
    if (src_rows_q < DIM_W'(2))               sr = SDW'(2);
    else if (32'(src_rows_q) > MAX_SRC_DIM)   sr = SDW'(MAX_SRC_DIM);
    else                                      sr = SDW'(src_rows_q);
    if (src_cols_q < DIM_W'(2))               sc = SDW'(2);
    else if (32'(src_cols_q) > MAX_SRC_DIM)   sc = SDW'(MAX_SRC_DIM);
    else                                      sc = SDW'(src_cols_q);
    if (out_rows_q < DIM_W'(1))               orr = ODW'(1);
    else if (32'(out_rows_q) > MAX_OUT_DIM)   orr = ODW'(MAX_OUT_DIM);
    else                                      orr = ODW'(out_rows_q);
    if (out_cols_q < DIM_W'(1))               occ = ODW'(1);
    else if (32'(out_cols_q) > MAX_OUT_DIM)   occ = ODW'(MAX_OUT_DIM);
    else                                      occ = ODW'(out_cols_q);
  end

  assign sr_last  = SIW'(sr - SDW'(1));
  assign sc_last  = SIW'(sc - SDW'(1));
  assign orr_last = OIW'(orr - ODW'(1));
  assign occ_last = OIW'(occ - ODW'(1));
  assign npix     = SNW'(sr) * SNW'(sc);
  assign load_ok  = load_idx_q < npix;
  assign cfg_hit  = cfg_we_i && (cfg_idx_i <= CFG_ROW_OFF);

  // neighbour indices and weights from the current position
  logic [IW-1:0]  iy, ix;
  logic [IW1-1:0] iy1, ix1;
  logic [SIW-1:0] y0_d, y1_d, x0_d, x1_d;

  assign iy  = pos_y_q[PW-1:16];
  assign ix  = pos_x_q[PW-1:16];
  assign iy1 = IW1'(iy) + IW1'(1);
  assign ix1 = IW1'(ix) + IW1'(1);
  assign y0_d = (iy > IW'(sr_last)) ? sr_last : SIW'(iy);
  assign y1_d = (iy1 > IW1'(sr_last)) ? sr_last : SIW'(iy1);
  assign x0_d = (ix > IW'(sc_last)) ? sc_last : SIW'(ix);
  assign x1_d = (ix1 > IW1'(sc_last)) ? sc_last : SIW'(ix1);

  // memories
  logic [SAW-1:0]      src_raddr;
  logic [SAMPLE_W-1:0] src_rdata;
  logic                src_we;
  logic                res_we;
  logic [VAL_W-1:0]    res_rdata;
  logic [VAL_W-1:0]    v_round;

  assign src_we = (cmd_i.op == DP_LOAD) && load_ok;
  assign res_we = (cmd_i.op == DP_G_WR);

  always_comb begin
    case (cmd_i.op)
      DP_G_RD01: src_raddr = rb0_q + SAW'(x1_q);
      DP_G_RD10: src_raddr = rb1_q + SAW'(x0_q);
      DP_G_RD11: src_raddr = rb1_q + SAW'(x1_q);
      default:   src_raddr = rb0_q + SAW'(x0_q);
    endcase
  end

  bpr_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SRC_DIM * MAX_SRC_DIM)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (load_idx_q[SAW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  bpr_ram #(.WIDTH(VAL_W), .DEPTH(1 << OAW)) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (res_we),
    .waddr_i (g_idx_q),
    .wdata_i (v_round),
    .raddr_i (rd_idx_q),
    .rdata_o (res_rdata)
  );

  // shared multipliers: sample by column weight, row sum by row weight
  logic [WGT_W-1:0] wa, wb;
  logic [H_W-1:0]   prod_a;
  logic [ACC_W-1:0] prod_b;

  assign wa     = (cmd_i.op == DP_G_RD01 || cmd_i.op == DP_G_RD11) ? gx_q : fx_q;
  assign wb     = (cmd_i.op == DP_G_RD11) ? gy_q : fy_q;
  assign prod_a = H_W'(src_rdata) * H_W'(wa);
  assign prod_b = ACC_W'(h_q) * ACC_W'(wb);
  assign v_round = VAL_W'((acc_q + ROUND_HALF) >> 8);

  // restoring divider step
  logic [RW-1:0] rem2, sum_ext;
  logic          ge;

  assign sum_ext = RW'(sum_q);
  assign rem2    = {rem_q[RW-2:0], 1'b0};
  assign ge      = rem2 >= sum_ext;

  logic g_last, r_last;
  assign g_last = (g_row_q == orr_last) && (g_col_q == occ_last);
  assign r_last = (rd_row_q == orr_last) && (rd_col_q == occ_last);

  assign sts_o.computed  = computed_q;
  assign sts_o.grid_last = g_last;
  assign sts_o.skip_div  = (sum_q == '0) || (SUM_W'(res_rdata) >= sum_q);
  assign sts_o.div_done  = div_cnt_q == DCNT_W'(DIV_STEPS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rows_q  <= SRC_ROWS_RST;
      src_cols_q  <= SRC_COLS_RST;
      out_rows_q  <= OUT_ROWS_RST;
      out_cols_q  <= OUT_COLS_RST;
      step_q      <= STEP_RST;
      col_off_q   <= OFFSET_RST;
      row_off_q   <= OFFSET_RST;
      computed_q  <= 1'b0;
      load_idx_q  <= '0;
      rd_idx_q    <= '0;
      rd_row_q    <= '0;
      rd_col_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SRC_ROWS: src_rows_q <= cfg_data_i[DIM_W-1:0];
          CFG_SRC_COLS: src_cols_q <= cfg_data_i[DIM_W-1:0];
          CFG_OUT_ROWS: out_rows_q <= cfg_data_i[DIM_W-1:0];
          CFG_OUT_COLS: out_cols_q <= cfg_data_i[DIM_W-1:0];
          CFG_STEP:     step_q     <= cfg_data_i;
          CFG_COL_OFF:  col_off_q  <= cfg_data_i;
          CFG_ROW_OFF:  row_off_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        computed_q <= 1'b0;
        rd_idx_q   <= '0;
        rd_row_q   <= '0;
        rd_col_q   <= '0;
      end
      case (cmd_i.op)
        DP_LOAD: begin
          if (load_ok) begin
            load_idx_q <= load_idx_q + SNW'(1);
          end
          computed_q <= 1'b0;
          rd_idx_q   <= '0;
          rd_row_q   <= '0;
          rd_col_q   <= '0;
        end
        DP_G_WR: begin
          if (g_last) begin
            computed_q <= 1'b1;
          end
        end
        DP_R_OUT: begin
          if (r_last) begin
            rd_idx_q   <= '0;
            rd_row_q   <= '0;
            rd_col_q   <= '0;
            load_idx_q <= '0;
            computed_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + OAW'(1);
            if (rd_col_q == occ_last) begin
              rd_col_q <= '0;
              rd_row_q <= rd_row_q + OIW'(1);
            end else begin
              rd_col_q <= rd_col_q + OIW'(1);
            end
          end
        end
        default: ;
      endcase
      if (cmd_i.op == DP_R_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_G_INIT: begin
        g_idx_q <= '0;
        g_row_q <= '0;
        g_col_q <= '0;
        pos_y_q <= PW'(row_off_q);
        pos_x_q <= PW'(col_off_q);
        sum_q   <= '0;
      end
      DP_G_IDX: begin
        y0_q <= y0_d;
        y1_q <= y1_d;
        x0_q <= x0_d;
        x1_q <= x1_d;
        fy_q <= WGT_W'(pos_y_q[15:0]);
        fx_q <= WGT_W'(pos_x_q[15:0]);
        gy_q <= FRAC_ONE - WGT_W'(pos_y_q[15:0]);
        gx_q <= FRAC_ONE - WGT_W'(pos_x_q[15:0]);
      end
      DP_G_BASE: begin
        rb0_q <= SAW'(y0_q) * SAW'(sc);
        rb1_q <= SAW'(y1_q) * SAW'(sc);
      end
      DP_G_RD01: h_q <= prod_a;
      DP_G_RD10: h_q <= h_q + prod_a;
      DP_G_RD11: begin
        acc_q <= prod_b;
        h_q   <= prod_a;
      end
      DP_G_MUL: h_q <= h_q + prod_a;
      DP_G_ACC: acc_q <= acc_q + prod_b;
      DP_G_WR: begin
        sum_q   <= sum_q + SUM_W'(v_round);
        g_idx_q <= g_idx_q + OAW'(1);
        if (g_col_q == occ_last) begin
          g_col_q <= '0;
          g_row_q <= g_row_q + OIW'(1);
          pos_x_q <= PW'(col_off_q);
          pos_y_q <= pos_y_q + PW'(step_q);
        end else begin
          g_col_q <= g_col_q + OIW'(1);
          pos_x_q <= pos_x_q + PW'(step_q);
        end
      end
      DP_R_DATA: begin
        rem_q     <= RW'(res_rdata);
        quo_q     <= '0;
        div_cnt_q <= '0;
        zero_q    <= sum_q == '0;
        sat_q     <= SUM_W'(res_rdata) >= sum_q;
      end
      DP_R_DIV: begin
        rem_q     <= ge ? (rem2 - sum_ext) : rem2;
        quo_q     <= {quo_q[Q_W-2:0], ge};
        div_cnt_q <= div_cnt_q + DCNT_W'(1);
      end
      DP_R_OUT: begin
        out_val_q  <= zero_q ? '0 : (sat_q ? Q24_MAX : quo_q);
        out_row_q  <= rd_row_q;
        out_col_q  <= rd_col_q;
        out_last_q <= r_last;
        out_zero_q <= zero_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_val_q;
  assign pixel_row_o   = 8'(out_row_q);
  assign pixel_col_o   = 8'(out_col_q);
  assign is_last_o     = out_last_q;
  assign zero_total_o  = out_zero_q;

`ifndef ASSERT_OFF
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_zero_q |-> out_val_q == '0)
    else $error("zero total with non-zero value");
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_LOAD && !load_ok |=> $stable(load_idx_q))
    else $error("load index moved past image size");
  a_grid_sets_computed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == DP_G_WR && g_last && !cfg_hit |=> computed_q)
    else $error("grid pass finished without marking computed");
`endif
endmodule

[hw/rtl/bilinear_psf_resample_top.sv]
// Top level of the bilinear resampler with normalisation by the grid total.
// Load beat: one per cycle while the sequencer is idle, no result.
// First read after a load or register write: a grid pass (one shared source RAM port,
// four reads per pixel), then a read.
// Read: fetch, one-bit-per-cycle divider unless saturated or zero, then output.
// Reset: registers to defaults, counters cleared; RAM contents stay undefined, no clear.
module bilinear_psf_resample_top import bpr_pkg::*; #(
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF,
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bpr_in_if.sink                in_if,
  bpr_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  bpr_cmd_t cmd;
  bpr_sts_t sts;

  // sequencer: takes beats only when idle, steps the datapath through each job
  bpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_op_i    (in_if.operation),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: holds the stores, the interpolator, the divider and the result register
  bpr_dp #(
    .MAX_SRC_DIM (MAX_SRC_DIM),
    .MAX_OUT_DIM (MAX_OUT_DIM)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_i      (in_if.sample),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .pixel_value_o (out_if.pixel_value),
    .pixel_row_o   (out_if.pixel_row),
    .pixel_col_o   (out_if.pixel_col),
    .is_last_o     (out_if.is_last),
    .zero_total_o  (out_if.zero_total)
  );
endmodule

[verif/tb.sv]
// Self-checking testbench for the bilinear resampler with grid-total normalisation.
module tb;
  import bpr_pkg::*;

  typedef struct {
    operation_e       op;
    logic [SAMPLE_W-1:0] sample;
  } beat_t;

  typedef struct {
    logic [Q_W-1:0] value;
    logic [7:0]     row;
    logic [7:0]     col;
    logic           last;
    logic           zero;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpr_in_if  in_ch ();
  bpr_out_if out_ch ();

  bilinear_psf_resample_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Beats still to send, and normalised pixels still owed by the block.
  beat_t  beat_q[$];
  pixel_t pixel_q[$];
  int     mismatches = 0;
  int     beats_made = 0;
  bit     long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Resampler shadow: registers, source image, grid and counters.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] sh_src_rows = SRC_ROWS_RST, sh_src_cols = SRC_COLS_RST;
  logic [DIM_W-1:0] sh_out_rows = OUT_ROWS_RST, sh_out_cols = OUT_COLS_RST;
  logic [Q_W-1:0]   sh_step = STEP_RST, sh_col_off = OFFSET_RST, sh_row_off = OFFSET_RST;
  logic [SAMPLE_W-1:0] src_img [65536];
  logic [VAL_W-1:0]    grid_img [65536];
  logic [SUM_W-1:0]    grid_total = '0;
  int unsigned         load_pos = 0, read_pos = 0;
  bit                  grid_ready = 1'b0;

  function automatic int unsigned sat_dim(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int unsigned clip_idx(longint unsigned v, int unsigned last_idx);
    return (v > last_idx) ? last_idx : int'(v);
  endfunction

  // Interpolate the whole output grid and total it.
  task automatic resample_grid();
    int unsigned sr, sc, orr, oc, y0, y1, x0, x1;
    longint unsigned py, px, fy, fx, gy, gx, acc, v;
    sr  = sat_dim(sh_src_rows, 2, MAX_SRC_DIM_DEF);
    sc  = sat_dim(sh_src_cols, 2, MAX_SRC_DIM_DEF);
    orr = sat_dim(sh_out_rows, 1, MAX_OUT_DIM_DEF);
    oc  = sat_dim(sh_out_cols, 1, MAX_OUT_DIM_DEF);
    grid_total = '0;
    for (int unsigned r = 0; r < orr; r++) begin
      py = longint'(sh_row_off) + longint'(r) * longint'(sh_step);
      fy = py & 64'hFFFF;
      gy = 64'h10000 - fy;
      y0 = clip_idx(py >> 16, sr - 1);
      y1 = clip_idx((py >> 16) + 1, sr - 1);
      for (int unsigned c = 0; c < oc; c++) begin
        px = longint'(sh_col_off) + longint'(c) * longint'(sh_step);
        fx = px & 64'hFFFF;
        gx = 64'h10000 - fx;
        x0 = clip_idx(px >> 16, sc - 1);
        x1 = clip_idx((px >> 16) + 1, sc - 1);
        acc = longint'(src_img[y0*sc + x0]) * (gy * gx)
            + longint'(src_img[y0*sc + x1]) * (gy * fx)
            + longint'(src_img[y1*sc + x0]) * (fy * gx)
            + longint'(src_img[y1*sc + x1]) * (fy * fx);
        v = (acc + 128) >> 8;
        grid_img[r*oc + c] = v[VAL_W-1:0];
        grid_total += v[SUM_W-1:0];
      end
    end
    grid_ready = 1'b1;
  endtask

  // Apply one accepted beat; a read queues the pixel it must return.
  task automatic apply_beat(beat_t b);
    int unsigned n, oc, idx;
    logic [63:0] q;
    pixel_t px;
    if (b.op == OPERATION_LOAD) begin
      if (load_pos < sat_dim(sh_src_rows, 2, MAX_SRC_DIM_DEF) *
                     sat_dim(sh_src_cols, 2, MAX_SRC_DIM_DEF)) begin
        src_img[load_pos] = b.sample;
        load_pos++;
      end
      grid_ready = 1'b0;
      read_pos = 0;
    end else begin
      oc = sat_dim(sh_out_cols, 1, MAX_OUT_DIM_DEF);
      n  = sat_dim(sh_out_rows, 1, MAX_OUT_DIM_DEF) * oc;
      if (!grid_ready) resample_grid();
      if (read_pos >= n) read_pos = 0;
      idx = read_pos;
      px.zero  = (grid_total == '0);
      px.value = '0;
      if (!px.zero) begin
        q = {grid_img[idx], 24'b0} / {8'b0, grid_total};
        px.value = (q > 64'(Q24_MAX)) ? Q24_MAX : q[Q_W-1:0];
      end
      px.row  = 8'(idx / oc);
      px.col  = 8'(idx % oc);
      px.last = (idx == n - 1);
      pixel_q.push_back(px);
      if (px.last) begin
        read_pos = 0;
        load_pos = 0;
        grid_ready = 1'b0;
      end else begin
        read_pos = idx + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats with random gaps; hold a beat until it is taken.
  // ---------------------------------------------------------------------------
  int burst_left = 0, gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OPERATION_LOAD;
      in_ch.sample <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_beat(beat_q.pop_front());
        if (burst_left > 0) burst_left--;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered beat unchanged
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // now and then run without gaps
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.operation <= beat_q[0].op;
          in_ch.sample <= beat_q[0].sample;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern changes at random intervals; one long hold-off.
  // ---------------------------------------------------------------------------
  int  mode_left = 0, rx_mode = 0, hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 600;
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel checker: compare every taken beat with the oldest owed pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel beat row %0d col %0d", out_ch.pixel_row, out_ch.pixel_col);
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (out_ch.pixel_value !== want.value) begin
          $error("pixel_value: expected %h, got %h", want.value, out_ch.pixel_value);
          mismatches++;
        end
        if (out_ch.pixel_row !== want.row) begin
          $error("pixel_row: expected %0d, got %0d", want.row, out_ch.pixel_row);
          mismatches++;
        end
        if (out_ch.pixel_col !== want.col) begin
          $error("pixel_col: expected %0d, got %0d", want.col, out_ch.pixel_col);
          mismatches++;
        end
        if (out_ch.is_last !== want.last) begin
          $error("is_last: expected %b, got %b", want.last, out_ch.is_last);
          mismatches++;
        end
        if (out_ch.zero_total !== want.zero) begin
          $error("zero_total: expected %b, got %b", want.zero, out_ch.zero_total);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Wait until every beat is taken and every pixel returned, then let the block drain.
  task automatic settle();
    while (beat_q.size() > 0 || in_ch.valid || pixel_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Write one register; the shadow follows at the same edge.
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SRC_ROWS: sh_src_rows = data[DIM_W-1:0];
      CFG_SRC_COLS: sh_src_cols = data[DIM_W-1:0];
      CFG_OUT_ROWS: sh_out_rows = data[DIM_W-1:0];
      CFG_OUT_COLS: sh_out_cols = data[DIM_W-1:0];
      CFG_STEP:     sh_step = data;
      CFG_COL_OFF:  sh_col_off = data;
      CFG_ROW_OFF:  sh_row_off = data;
      default: return;
    endcase
    grid_ready = 1'b0;
    read_pos = 0;
  endtask

  task automatic reg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_beat(operation_e op, logic [SAMPLE_W-1:0] s);
    beat_t b;
    b.op = op;
    b.sample = s;
    beat_q.push_back(b);
    beats_made++;
  endtask

  // Load a full image (fill: 0 random, 1 zero, 2 full scale), then read it out
  // to its last pixel, with a partial read and a stray load first if asked.
  task automatic image_pass(int fill, bit stray);
    int unsigned ns, n, k;
    ns = sat_dim(sh_src_rows, 2, MAX_SRC_DIM_DEF) * sat_dim(sh_src_cols, 2, MAX_SRC_DIM_DEF);
    n  = sat_dim(sh_out_rows, 1, MAX_OUT_DIM_DEF) * sat_dim(sh_out_cols, 1, MAX_OUT_DIM_DEF);
    for (int unsigned i = 0; i < ns + $urandom_range(0, 2); i++)
      push_beat(OPERATION_LOAD, (fill == 1) ? 16'h0000 :
                                (fill == 2) ? 16'hFFFF : 16'($urandom));
    if (stray) begin
      k = $urandom_range(0, n - 1);
      repeat (k) push_beat(OPERATION_READ, 16'($urandom));
      push_beat(OPERATION_LOAD, 16'($urandom));
    end
    repeat (n) push_beat(OPERATION_READ, 16'($urandom));
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OPERATION_LOAD;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Small image on the reset step and offsets.
    reg_write(CFG_SRC_ROWS, 24'd2);
    reg_write(CFG_SRC_COLS, 24'd3);
    reg_write(CFG_OUT_ROWS, 24'd2);
    reg_write(CFG_OUT_COLS, 24'd2);
    reg_close();
    image_pass(0, 1'b0);
    settle();

    // All-zero image: zero total, half-pixel step.
    reg_write(CFG_STEP, 24'h008000);
    reg_write(CFG_OUT_ROWS, 24'd3);
    reg_write(CFG_OUT_COLS, 24'd3);
    reg_close();
    image_pass(1, 1'b0);
    settle();

    // Single output pixel carries the whole total: saturated value.
    reg_write(CFG_OUT_ROWS, 24'd1);
    reg_write(CFG_OUT_COLS, 24'd1);
    reg_close();
    image_pass(2, 1'b0);
    settle();

    // Zero step with offsets far past the image: every neighbour clamps.
    reg_write(CFG_STEP, 24'd0);
    reg_write(CFG_COL_OFF, 24'hFFFFFF);
    reg_write(CFG_ROW_OFF, 24'hFFFFFF);
    reg_write(CFG_OUT_ROWS, 24'd2);
    reg_write(CFG_OUT_COLS, 24'd3);
    reg_write(3'd7, 24'hFFFFFF);
    reg_close();
    image_pass(0, 1'b1);
    settle();

    // Largest step; undersized source dimensions, oversized output columns.
    reg_write(CFG_STEP, 24'hFFFFFF);
    reg_write(CFG_COL_OFF, 24'h00C000);
    reg_write(CFG_ROW_OFF, 24'h000001);
    reg_write(CFG_SRC_ROWS, 24'd0);
    reg_write(CFG_SRC_COLS, 24'd1);
    reg_write(CFG_OUT_ROWS, 24'd0);
    reg_write(CFG_OUT_COLS, 24'h1FF);
    reg_close();
    image_pass(0, 1'b0);
    settle();

    // Tall source and output at their limits; hold off the receiver once the
    // first pixel is waiting, so later reads back up behind it.
    reg_write(CFG_SRC_ROWS, 24'h1FF);
    reg_write(CFG_SRC_COLS, 24'd2);
    reg_write(CFG_OUT_ROWS, 24'd256);
    reg_write(CFG_OUT_COLS, 24'd1);
    reg_write(CFG_STEP, 24'h00FF00);
    reg_write(CFG_COL_OFF, 24'h008000);
    reg_write(CFG_ROW_OFF, 24'h000000);
    reg_close();
    image_pass(0, 1'b0);
    wait (out_ch.valid);
    @(negedge clk_i);
    long_hold_req = 1'b1;
    settle();

    // Random small images with random geometry.
    while (beats_made < 1200) begin
      reg_write(CFG_SRC_ROWS, 24'($urandom_range(0, 10)));
      reg_write(CFG_SRC_COLS, 24'($urandom_range(0, 10)));
      reg_write(CFG_OUT_ROWS, 24'($urandom_range(0, 9)));
      reg_write(CFG_OUT_COLS, 24'($urandom_range(0, 9)));
      reg_write(CFG_STEP, ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 3 << 16)));
      reg_write(CFG_COL_OFF, ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                         : 24'($urandom_range(0, 4 << 16)));
      reg_write(CFG_ROW_OFF, ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                         : 24'($urandom_range(0, 4 << 16)));
      reg_close();
      image_pass(($urandom_range(0, 9) == 0) ? 1 : 0, $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 1) == 0) image_pass(0, 1'b0);
      settle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
